// ===== hdl/shabsh_pkg.sv =====
// ============================================================================
// SHA-256 byte stream hasher package
// Shared item types, controller to datapath commands and hash constants.
// ============================================================================
package shabsh_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } t_out_item;

    localparam logic [1:0] SEL_MSG   = 2'd0;
    localparam logic [1:0] SEL_PAD80 = 2'd1;
    localparam logic [1:0] SEL_ZERO  = 2'd2;
    localparam logic [1:0] SEL_LEN   = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic       shift_en;
        logic [1:0] byte_sel;
        logic       count_en;
        logic       start_msg;
        logic       load_vars;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_en;
        logic       emit;
        logic       emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_stat;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ===== hdl/shabsh_datapath.sv =====
// ============================================================================
// SHA-256 datapath
// Byte shift window and message schedule, round unit, chaining value,
// message length counter and digest output register.
// ============================================================================
module shabsh_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  shabsh_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]           i_msg_byte,
    output shabsh_pkg::t_dp_stat o_stat,
    output shabsh_pkg::t_out_item o_out_data
);
    import shabsh_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] n_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    t_out_item   r_out;

    logic [63:0] bit_len;
    logic [7:0]  len_byte;
    logic [7:0]  in_byte;
    logic [31:0] new_w;
    logic [31:0] t1;
    logic [31:0] t2;

    assign bit_len = {r_count, 3'b000};

    always_comb begin
        case (r_fill[2:0])
            3'd0:    len_byte = bit_len[63:56];
            3'd1:    len_byte = bit_len[55:48];
            3'd2:    len_byte = bit_len[47:40];
            3'd3:    len_byte = bit_len[39:32];
            3'd4:    len_byte = bit_len[31:24];
            3'd5:    len_byte = bit_len[23:16];
            3'd6:    len_byte = bit_len[15:8];
            default: len_byte = bit_len[7:0];
        endcase
    end

    always_comb begin
        unique case (i_cmd.byte_sel)
            SEL_MSG:   in_byte = i_msg_byte;
            SEL_PAD80: in_byte = PAD_BYTE;
            SEL_ZERO:  in_byte = 8'h00;
            SEL_LEN:   in_byte = len_byte;
            default:   in_byte = 8'h00;
        endcase
    end

    assign new_w = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[i_cmd.round_idx] + r_w[0];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_w[i] = r_w[i];
        end
        if (i_cmd.shift_en) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = {r_w[i][23:0], r_w[i+1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], in_byte};
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                n_w[i] = r_w[i+1];
            end
            n_w[15] = new_w;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            r_w[i] <= n_w[i];
        end
        if (i_cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round_en) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
        if (i_cmd.emit) begin
            r_out.digest_word <= r_h[0];
            r_out.last_word   <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= INIT_HASH[i];
            end
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.start_msg) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= INIT_HASH[i];
                end
                r_fill  <= '0;
                r_count <= '0;
            end else begin
                if (i_cmd.add_en) begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                end else if (i_cmd.emit) begin
                    for (int i = 0; i < 7; i++) begin
                        r_h[i] <= r_h[i+1];
                    end
                    r_h[7] <= r_h[0];
                end
                if (i_cmd.shift_en) begin
                    r_fill <= r_fill + 6'd1;
                end
                if (i_cmd.count_en) begin
                    r_count <= r_count + 61'd1;
                end
            end
        end
    end

    assign o_stat.fill = r_fill;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/shabsh_ctrl.sv =====
// ============================================================================
// SHA-256 controller
// Sequences byte intake, padding, the 64 compression rounds and the
// transfer of the eight digest words.
// ============================================================================
module shabsh_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_byte_present,
    input  logic                  i_end_of_message,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  shabsh_pkg::t_dp_stat  i_stat,
    output shabsh_pkg::t_dp_cmd   o_cmd
);
    import shabsh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_word, n_word;
    logic       r_pad_active, n_pad_active;
    logic       r_sent80, n_sent80;
    logic       r_len_mode, n_len_mode;
    logic       r_out_valid, n_out_valid;
    logic       in_fire;
    logic       can_load;
    logic       full_next;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign can_load   = !r_out_valid || i_out_ready;
    assign full_next  = (i_stat.fill == 6'd63);

    always_comb begin
        n_state      = r_state;
        n_round      = r_round;
        n_word       = r_word;
        n_pad_active = r_pad_active;
        n_sent80     = r_sent80;
        n_len_mode   = r_len_mode;
        o_cmd        = '0;
        o_cmd.byte_sel  = SEL_MSG;
        o_cmd.round_idx = r_round;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_byte_present) begin
                        o_cmd.shift_en = 1'b1;
                        o_cmd.count_en = 1'b1;
                        n_pad_active   = i_end_of_message;
                        if (full_next) begin
                            n_state = S_LOAD;
                        end else if (i_end_of_message) begin
                            n_state = S_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_pad_active = 1'b1;
                        n_state      = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift_en = 1'b1;
                if (!r_sent80) begin
                    o_cmd.byte_sel = SEL_PAD80;
                    n_sent80       = 1'b1;
                    n_len_mode     = (i_stat.fill <= 6'd55);
                end else if (r_len_mode && i_stat.fill >= 6'd56) begin
                    o_cmd.byte_sel = SEL_LEN;
                end else begin
                    o_cmd.byte_sel = SEL_ZERO;
                end
                if (full_next) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_vars = 1'b1;
                n_round         = 6'd0;
                n_state         = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round        = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_en = 1'b1;
                if (r_pad_active && r_len_mode) begin
                    n_word  = 3'd0;
                    n_state = S_OUT;
                end else if (r_pad_active) begin
                    if (r_sent80) begin
                        n_len_mode = 1'b1;
                    end
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (can_load) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = (r_word == 3'd7);
                    n_word          = r_word + 3'd1;
                    if (r_word == 3'd7) begin
                        o_cmd.start_msg = 1'b1;
                        n_pad_active    = 1'b0;
                        n_sent80        = 1'b0;
                        n_len_mode      = 1'b0;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_round      <= '0;
            r_word       <= '0;
            r_pad_active <= 1'b0;
            r_sent80     <= 1'b0;
            r_len_mode   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_round      <= n_round;
            r_word       <= n_word;
            r_pad_active <= n_pad_active;
            r_sent80     <= n_sent80;
            r_len_mode   <= n_len_mode;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("digest word loaded over a word not yet transferred");

    a_round_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round != 6'd63)
            |=> (r_state == S_ROUND && r_round == $past(r_round) + 6'd1))
        else $error("compression rounds did not advance by one");

    a_pad_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD || r_state == S_OUT) |-> r_pad_active)
        else $error("padding or digest transfer outside message end");

    a_digest_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_pad_active && r_len_mode) |=> (r_state == S_OUT))
        else $error("final block did not lead to digest transfer");

endmodule

// ===== hdl/sha256_byte_stream_hasher.sv =====
// A byte without end mark is taken whenever the hasher is idle; each full 64-byte block then holds
// input off while it is compressed (load, 64 rounds of the single round unit, chaining add).
// End of message: pad and length bytes enter one per cycle save while a block is compressed,
// one or two blocks are compressed, then the eight digest words leave one per cycle as the
// output side takes them. Sustained throughput is set by the one-round-per-cycle compressor.
// Synchronous active-low reset loads the initial hash words and clears all counters.
// ============================================================================
// SHA-256 byte stream hasher
// Top level joining the controller and datapath for byte-wise SHA-256.
// ============================================================================
module sha256_byte_stream_hasher (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  shabsh_pkg::t_in_item    i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output shabsh_pkg::t_out_item   o_out_data
);
    import shabsh_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    shabsh_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_present   (i_in_data.byte_present),
        .i_end_of_message (i_in_data.end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_stat           (dp_stat),
        .o_cmd            (dp_cmd)
    );

    shabsh_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_msg_byte (i_in_data.message_byte),
        .o_stat     (dp_stat),
        .o_out_data (o_out_data)
    );

endmodule
